// ===== rtl/core/s16plm_pkg.sv =====
// Shared types and constants for the s16 peak level meter.
// No dependencies; used by sample_to_s16_peak_level_meter.
package s16plm_pkg;

  // Source sample encodings
  typedef enum logic [1:0] {
    FMT_INT16   = 2'd0,
    FMT_INT24   = 2'd1,
    FMT_INT32   = 2'd2,
    FMT_FLOAT32 = 2'd3
  } fmt_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES = 8'd1;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WINDOW_W   = 18;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 18'd8000;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned LEVEL_Q_W = 23;
  localparam int unsigned LEVEL_W  = 7;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  // Float32 field layout and conversion constants
  localparam logic [7:0] EXP_ONE      = 8'd127;
  localparam logic [7:0] EXP_SPECIAL  = 8'hFF;
  localparam logic [7:0] SHIFT_BIAS   = 8'd150;
  localparam logic [7:0] SHIFT_DENORM = 8'd149;
  localparam int unsigned PROD_W      = 39;   // 24-bit mantissa times 32767
  localparam logic [14:0] FULL_SCALE  = 15'd32767;

  // floor(n / 10) as (n * DIV10_MULT) >> DIV10_SHIFT, exact for n < 2^32
  localparam logic [31:0] DIV10_MULT  = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  // Pipeline payload between the conversion and state stages
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [MAG_W-1:0]    mag;
    logic                frame_end;
    logic                packet_end;
  } conv_t;

  // Pipeline payload between the state stage and the output stage
  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample;
    logic                 report;
    logic [LEVEL_Q_W-1:0] level_q16;
  } meter_t;

endpackage

// ===== rtl/core/sample_to_s16_peak_level_meter.sv =====
// Sample converter to signed 16-bit with a windowed peak level meter.
// Each item passes the input, conversion, state and output registers in that order.
// Throughput: one item per cycle while m_tready holds; a stage takes a new item
// whenever it is empty or its item moves on, so bubbles absorb output stalls.
// Reset (rst, synchronous): pipeline empties, peak, frame count and last
// level clear, sample_format returns to int16 and window_frames to 8000.
// Depends on s16plm_pkg.
module sample_to_s16_peak_level_meter (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [s16plm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [s16plm_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_raw
  input  logic        s_tuser,   // [0] frame_end
  input  logic        s_tlast,   // packet_end
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] sample_out, [22:16] level, [23] zero
  output logic        m_tuser    // [0] level_valid
);

  // ---------------------------------------------------------------------
  // Config registers, always ready; written only while idle by user, unenforced
  // ---------------------------------------------------------------------
  s16plm_pkg::fmt_t                      sample_format;
  logic [s16plm_pkg::WINDOW_W-1:0]       window_frames;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= s16plm_pkg::FMT_INT16;
      window_frames <= s16plm_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        s16plm_pkg::REG_SAMPLE_FORMAT: begin
          sample_format <= s16plm_pkg::fmt_t'(cfg_data[1:0]);
        end
        s16plm_pkg::REG_WINDOW_FRAMES: begin
          window_frames <= cfg_data[s16plm_pkg::WINDOW_W-1:0];
        end
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: each stage loads when empty or when it drains
  // ---------------------------------------------------------------------
  logic in_valid, conv_valid, meter_valid;
  logic conv_ready, meter_ready, out_ready;

  assign out_ready   = !m_tvalid    || m_tready;
  assign meter_ready = !meter_valid || out_ready;
  assign conv_ready  = !conv_valid  || meter_ready;
  assign s_tready    = !in_valid    || conv_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      conv_valid  <= 1'b0;
      meter_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (s_tready)    in_valid    <= s_tvalid;
      if (conv_ready)  conv_valid  <= in_valid;
      if (meter_ready) meter_valid <= conv_valid;
      if (out_ready)   m_tvalid    <= meter_valid;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------
  logic [31:0] raw;
  logic        raw_frame_end;
  logic        raw_packet_end;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      raw            <= s_tdata;
      raw_frame_end  <= s_tuser;
      raw_packet_end <= s_tlast;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: convert to signed 16-bit and take the magnitude
  // ---------------------------------------------------------------------
  logic [7:0]                       f_exp;
  logic [22:0]                      f_frac;
  logic [23:0]                      f_mant;
  logic [7:0]                       f_shift;
  logic [s16plm_pkg::PROD_W-1:0]    f_prod;
  logic [s16plm_pkg::PROD_W-1:0]    f_scaled;
  logic [14:0]                      f_mag;
  logic [s16plm_pkg::SAMPLE_W-1:0]  f_sample;
  logic [s16plm_pkg::SAMPLE_W-1:0]  conv_sample;
  logic [s16plm_pkg::MAG_W-1:0]     conv_mag;
  s16plm_pkg::conv_t                conv_q;

  always_comb begin
    f_exp  = raw[30:23];
    f_frac = raw[22:0];
    // subnormals have no hidden one and sit one exponent step higher
    if (f_exp == 8'd0) begin
      f_mant  = {1'b0, f_frac};
      f_shift = s16plm_pkg::SHIFT_DENORM;
    end else begin
      f_mant  = {1'b1, f_frac};
      f_shift = s16plm_pkg::SHIFT_BIAS - f_exp;
    end
    // mantissa * 32767 as a shift and subtract
    f_prod = {f_mant, 15'd0} - {15'd0, f_mant};
    if (f_shift >= 8'(s16plm_pkg::PROD_W)) begin
      f_scaled = '0;
    end else begin
      f_scaled = f_prod >> f_shift[5:0];
    end

    if (f_exp == s16plm_pkg::EXP_SPECIAL && f_frac != 23'd0) begin
      f_mag = 15'd0;                       // NaN
    end else if (f_exp >= s16plm_pkg::EXP_ONE) begin
      f_mag = s16plm_pkg::FULL_SCALE;      // clamp at +-1, infinity included
    end else begin
      f_mag = f_scaled[14:0];
    end
    f_sample = raw[31] ? (16'd0 - {1'b0, f_mag}) : {1'b0, f_mag};

    unique case (sample_format)
      s16plm_pkg::FMT_INT16:   conv_sample = raw[15:0];
      s16plm_pkg::FMT_INT24:   conv_sample = raw[23:8];
      s16plm_pkg::FMT_INT32:   conv_sample = raw[31:16];
      s16plm_pkg::FMT_FLOAT32: conv_sample = f_sample;
      default:                 conv_sample = raw[15:0];
    endcase

    // full-scale negative gives 0x8000, which is right as unsigned
    conv_mag = conv_sample[15] ? (16'd0 - conv_sample) : conv_sample;
  end

  always_ff @(posedge clk) begin
    if (in_valid && conv_ready) begin
      conv_q.sample     <= conv_sample;
      conv_q.mag        <= conv_mag;
      conv_q.frame_end  <= raw_frame_end;
      conv_q.packet_end <= raw_packet_end;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: running peak, frame count and window check
  // ---------------------------------------------------------------------
  logic [s16plm_pkg::MAG_W-1:0]     peak_magnitude;
  logic [s16plm_pkg::COUNT_W-1:0]   frames_in_window;
  logic [s16plm_pkg::MAG_W-1:0]     peak_magnitude_next;
  logic [s16plm_pkg::COUNT_W-1:0]   frames_in_window_next;
  logic                             report_now;
  logic [s16plm_pkg::LEVEL_Q_W-1:0] level_raw_q16;
  s16plm_pkg::meter_t               meter_q;

  always_comb begin
    peak_magnitude_next = (conv_q.mag > peak_magnitude) ? conv_q.mag : peak_magnitude;
    frames_in_window_next = frames_in_window;
    if (conv_q.frame_end && frames_in_window != '1) begin
      frames_in_window_next = frames_in_window + 1'b1;
    end
    report_now = conv_q.packet_end &&
                 (frames_in_window_next >=
                  s16plm_pkg::COUNT_W'(window_frames));
    // peak * 200 = peak/32768 * 100 percent in Q16
    level_raw_q16 = ({7'd0, peak_magnitude_next} << 7) +
                    ({7'd0, peak_magnitude_next} << 6) +
                    ({7'd0, peak_magnitude_next} << 3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_magnitude   <= '0;
      frames_in_window <= '0;
    end else if (conv_valid && meter_ready) begin
      if (report_now) begin
        peak_magnitude   <= '0;
        frames_in_window <= '0;
      end else begin
        peak_magnitude   <= peak_magnitude_next;
        frames_in_window <= frames_in_window_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (conv_valid && meter_ready) begin
      meter_q.sample    <= conv_q.sample;
      meter_q.report    <= report_now;
      meter_q.level_q16 <= level_raw_q16;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: release smoothing and the output register
  // ---------------------------------------------------------------------
  logic [s16plm_pkg::LEVEL_Q_W-1:0] last_level_q16;
  logic                             falling;
  logic [26:0]                      blend_sum;
  logic [58:0]                      blend_prod;
  logic [s16plm_pkg::LEVEL_Q_W-1:0] level_q16_next;
  logic [s16plm_pkg::LEVEL_W-1:0]   level_int;
  logic [s16plm_pkg::LEVEL_W-1:0]   level_capped;

  always_comb begin
    falling = meter_q.level_q16 < last_level_q16;
    // 3*new + 7*old, then divide by ten through the reciprocal
    blend_sum = ({4'd0, meter_q.level_q16} << 1) + {4'd0, meter_q.level_q16} +
                ({4'd0, last_level_q16} << 3) - {4'd0, last_level_q16};
    blend_prod = 59'(blend_sum) * 59'(s16plm_pkg::DIV10_MULT);
    level_q16_next = falling ?
        blend_prod[s16plm_pkg::DIV10_SHIFT +: s16plm_pkg::LEVEL_Q_W] :
        meter_q.level_q16;
    level_int    = level_q16_next[16 +: s16plm_pkg::LEVEL_W];
    level_capped = (level_int > s16plm_pkg::LEVEL_MAX) ? s16plm_pkg::LEVEL_MAX : level_int;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level_q16 <= '0;
    end else if (meter_valid && out_ready && meter_q.report) begin
      last_level_q16 <= level_q16_next;
    end
  end

  always_ff @(posedge clk) begin
    if (meter_valid && out_ready) begin
      m_tdata[15:0]  <= meter_q.sample;
      m_tdata[22:16] <= meter_q.report ? level_capped : '0;
      m_tdata[23]    <= 1'b0;
      m_tuser        <= meter_q.report;
    end
  end

endmodule

// ===== tb/sv/sample_to_s16_peak_level_meter_test.sv =====
// Self-checking bench for sample_to_s16_peak_level_meter: sample conversion and level reports.
// Holds its own predictor of the meter in a small scoreboard class; the stimulus runs
// directed corner items, then random packets. Depends on s16plm_pkg and the block's RTL.
module sample_to_s16_peak_level_meter_test;
  import s16plm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  // One converted sample as it should leave the block
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                level_valid;
    logic [LEVEL_W-1:0]  level;
  } meter_result_t;

  // Predicts each result of the meter and checks the results in order
  class level_meter_scoreboard;
    fmt_t                 fmt;
    logic [WINDOW_W-1:0]  window;
    int unsigned          peak;
    logic [COUNT_W-1:0]   frames;
    logic [LEVEL_Q_W-1:0] last_q16;
    meter_result_t        expected_results[$];
    int                   mismatches;

    function new();
      fmt = FMT_INT16;
      window = WINDOW_RESET;
      peak = 0;
      frames = '0;
      last_q16 = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_SAMPLE_FORMAT) fmt = fmt_t'(data[1:0]);
      else if (idx == REG_WINDOW_FRAMES) window = data[WINDOW_W-1:0];
    endfunction

    // Float32 to s16: clamp at +-1, NaN gives zero, else the exact product truncated
    function logic [SAMPLE_W-1:0] float_to_s16(logic [31:0] bits);
      logic [7:0]  ex;
      logic [63:0] mant;
      logic [63:0] prod;
      int unsigned sh;
      logic [15:0] mag;
      ex = bits[30:23];
      if (ex == EXP_SPECIAL && bits[22:0] != '0) return '0;
      if (ex >= EXP_ONE) begin
        mag = {1'b0, FULL_SCALE};
      end else begin
        mant = (ex == 8'd0) ? {41'd0, bits[22:0]} : {40'd0, 1'b1, bits[22:0]};
        sh = (ex == 8'd0) ? 149 : 150 - ex;
        prod = mant * 64'd32767;
        mag = (sh >= 64) ? 16'd0 : 16'(prod >> sh);
      end
      return bits[31] ? -mag : mag;
    endfunction

    function void note_sample(logic [31:0] raw, logic frame_end, logic packet_end);
      meter_result_t r;
      int            sv;
      int unsigned   mag;
      int unsigned   lvl;
      case (fmt)
        FMT_INT16: r.sample = raw[15:0];
        FMT_INT24: r.sample = raw[23:8];
        FMT_INT32: r.sample = raw[31:16];
        default:   r.sample = float_to_s16(raw);
      endcase
      sv = $signed(r.sample);
      mag = (sv < 0) ? -sv : sv;
      r.level_valid = 1'b0;
      r.level = '0;
      // Peak first, then the frame count, then the window check
      if (mag > peak) peak = mag;
      if (frame_end && frames != '1) frames = frames + 1;
      if (packet_end && frames >= window) begin
        lvl = peak * 200;
        // Smooth only a falling level
        if (lvl < last_q16) lvl = (3 * lvl + 7 * last_q16) / 10;
        last_q16 = lvl[LEVEL_Q_W-1:0];
        lvl = lvl >> 16;
        r.level = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl[LEVEL_W-1:0];
        r.level_valid = 1'b1;
        peak = 0;
        frames = '0;
      end
      expected_results.push_back(r);
    endfunction

    function void check_output(logic [23:0] data, logic user);
      meter_result_t r;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected item: expected none, actual tdata %h tuser %b",
                 $time, data, user);
        mismatches++;
        return;
      end
      r = expected_results.pop_front();
      if (data[15:0] !== r.sample) begin
        $display("%0t sample_out: expected %h actual %h", $time, r.sample, data[15:0]);
        mismatches++;
      end
      if (user !== r.level_valid) begin
        $display("%0t level_valid: expected %b actual %b", $time, r.level_valid, user);
        mismatches++;
      end
      if (data[22:16] !== r.level) begin
        $display("%0t level: expected %0d actual %0d", $time, r.level, data[22:16]);
        mismatches++;
      end
      if (data[23] !== 1'b0) begin
        $display("%0t tdata pad bit: expected 0 actual %b", $time, data[23]);
        mismatches++;
      end
    endfunction

    function void close_out();
      if (expected_results.size() != 0) begin
        $display("%0t results never seen: expected %0d more, actual 0",
                 $time, expected_results.size());
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [31:0]           s_tdata;   // [31:0] sample_raw
  logic                  s_tuser;   // [0] frame_end
  logic                  s_tlast;   // packet_end
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;   // [15:0] sample_out, [22:16] level, [23] zero
  logic                  m_tuser;   // [0] level_valid

  int send_idle_pct;
  int recv_idle_pct;
  int cycles;
  level_meter_scoreboard sb;

  sample_to_s16_peak_level_meter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #2 clk = ~clk;

  // Receiver: stall at random, at the rate of the current stretch
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitors: note every accepted sample, check every accepted result
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_sample(s_tdata, s_tuser, s_tlast);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser);
  end

  // Watchdog: give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one sample, idling first at the sender's rate; return once it is taken
  task automatic push_sample(input logic [31:0] raw, input logic frame_end,
                             input logic packet_end);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    s_tuser  <= frame_end;
    s_tlast  <= packet_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Write both registers while the block is idle; junk goes into unused format bits
  task automatic configure(input fmt_t fmt, input logic [WINDOW_W-1:0] win);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(REG_SAMPLE_FORMAT, {junk[31:2], fmt});
    write_reg(REG_WINDOW_FRAMES, {14'd0, win});
    cfg_valid <= 1'b0;
  endtask

  // Raw sample for the given format; shift scales the magnitude down for level variety
  function automatic logic [31:0] make_raw(input fmt_t fmt, input int shift);
    logic [31:0] r;
    logic [15:0] v;
    logic [7:0]  ex;
    int          kind;
    r = $urandom();
    kind = $urandom_range(9);
    if (kind < 3) return r;
    if (fmt == FMT_FLOAT32) begin
      if (kind == 9) begin
        case ($urandom_range(6))
          0: return 32'h7F80_0000;
          1: return 32'hFF80_0000;
          2: return 32'h7FC0_0000;
          3: return 32'h3F80_0000;
          4: return 32'hBF80_0000;
          5: return 32'h0000_0001;
          default: return 32'h8000_0000;
        endcase
      end
      ex = 8'(127 - shift - $urandom_range(1));
      return {r[31], ex, r[22:0]};
    end
    if (kind == 9) v = r[0] ? 16'h8000 : 16'h7FFF;
    else begin
      v = 16'($urandom_range(32768 >> shift));
      if (r[0]) v = -v;
    end
    case (fmt)
      FMT_INT16: return {r[31:16], v};
      FMT_INT24: return {r[31:24], v, r[7:0]};
      default:   return {v, r[15:0]};
    endcase
  endfunction

  // Packets of whole frames with random content, plus a few broken flags
  task automatic random_packets(input fmt_t fmt, input int n_items);
    int   nch;
    int   ch;
    int   shift;
    logic fe;
    logic pe;
    nch = $urandom_range(1, 2);
    ch = 0;
    shift = $urandom_range(15);
    repeat (n_items) begin
      fe = (ch == nch - 1);
      if ($urandom_range(99) < 4) fe = !fe;
      pe = fe && ($urandom_range(99) < 30);
      if ($urandom_range(99) < 3) pe = !pe;
      push_sample(make_raw(fmt, shift), fe, pe);
      ch = (ch + 1 >= nch) ? 0 : ch + 1;
      if (pe) shift = $urandom_range(15);
    end
  endtask

  initial begin
    logic [WINDOW_W-1:0] win;
    sb = new();
    cycles = 0;
    send_idle_pct = 16;
    recv_idle_pct = 77;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    s_tlast   <= 1'b0;
    m_tready  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // int16: full scale both ways, a drop to silence, a report without a frame end
    configure(FMT_INT16, 18'd1);
    push_sample(32'hABCD_7FFF, 1'b1, 1'b1);
    push_sample(32'h0000_8000, 1'b1, 1'b1);
    push_sample(32'h1234_0000, 1'b1, 1'b1);
    push_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_sample(32'h0000_0001, 1'b1, 1'b0);
    push_sample(32'h5555_0002, 1'b0, 1'b1);
    drain();

    // int24: window of two frames, first packet end too early
    configure(FMT_INT24, 18'd2);
    push_sample(32'h1280_0000, 1'b1, 1'b1);
    push_sample(32'hFF7F_FFFF, 1'b1, 1'b0);
    push_sample(32'h0000_00FF, 1'b0, 1'b1);
    push_sample(32'h00FF_FF00, 1'b1, 1'b1);
    drain();

    // int32
    configure(FMT_INT32, 18'd3);
    push_sample(32'h8000_FFFF, 1'b1, 1'b0);
    push_sample(32'h7FFF_0000, 1'b1, 1'b0);
    push_sample(32'hFFFF_1234, 1'b1, 1'b1);
    drain();

    // float32 with a zero window: every packet end reports
    configure(FMT_FLOAT32, 18'd0);
    push_sample(32'h3F80_0000, 1'b0, 1'b1);   // +1.0
    push_sample(32'hBF80_0000, 1'b0, 1'b0);   // -1.0
    push_sample(32'h7F80_0000, 1'b0, 1'b1);   // +inf
    push_sample(32'hFF80_0000, 1'b1, 1'b0);   // -inf
    push_sample(32'h7FC0_0000, 1'b0, 1'b1);   // quiet NaN
    push_sample(32'h7F80_0001, 1'b0, 1'b0);   // signaling NaN
    push_sample(32'h3F00_0000, 1'b0, 1'b1);   // 0.5
    push_sample(32'h0000_0001, 1'b0, 1'b0);   // smallest denormal
    push_sample(32'h007F_FFFF, 1'b0, 1'b0);   // largest denormal
    push_sample(32'h3F7F_FFFF, 1'b0, 1'b1);   // just below one
    push_sample(32'h8000_0000, 1'b0, 1'b1);   // negative zero
    push_sample(32'h7F7F_FFFF, 1'b0, 1'b0);   // largest finite
    push_sample(32'hBF7F_FFFF, 1'b1, 1'b1);   // just above minus one
    drain();

    // Random phases: rotate formats and windows, extremes among them
    for (int p = 0; p < 10; p++) begin
      if (p == 4) begin
        send_idle_pct = 77;
        recv_idle_pct = 16;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: win = 18'd1;
        1: win = 18'd3;
        2: win = 18'd0;
        3: win = 18'd192000;
        4: win = 18'd2;
        5: win = 18'h3FFFF;
        6: win = 18'd5;
        7: win = 18'd1;
        8: win = 18'd8;
        default: win = 18'd4;
      endcase
      configure(fmt_t'(p % 4), win);
      random_packets(fmt_t'(p % 4), 150);
      drain();
    end

    // Let the pipeline settle, then judge
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/s16plm_pkg.sv
rtl/core/sample_to_s16_peak_level_meter.sv
tb/sv/sample_to_s16_peak_level_meter_test.sv
